FILE: hw/rtl/eeg_pkg.sv
// ----------------------------------------------------------------------------
// eeg_pkg: shared types and constants for the extended Euclid GCD unit
// Widths, controller commands and the status bundle used by controller and
// datapath.
// ----------------------------------------------------------------------------
package eeg_pkg;

    localparam int WIDTH   = 32;
    localparam int CWIDTH  = WIDTH + 1;
    localparam int CNT_W   = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0]         t_data;
    typedef logic signed [CWIDTH-1:0] t_coef;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture operands and set up initial rows
        logic div_start; // begin a serial division rp / rc
        logic div_step;  // one restoring division step
        logic upd_x;     // multiply-subtract for the big-operand row
        logic upd_y;     // multiply-subtract for the small-operand row and shift rows
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic small_zero; // smaller operand is zero
        logic div_done;   // all quotient bits produced
        logic rem_zero;   // remainder of last division is zero
    } t_status;

endpackage

FILE: hw/rtl/eeg_if.sv
// ----------------------------------------------------------------------------
// eeg_in_if / eeg_out_if: valid-ready channels of the GCD unit
// Operand and result transactions with source and sink modports.
// ----------------------------------------------------------------------------
interface eeg_in_if;
    logic           valid;
    logic           ready;
    eeg_pkg::t_data operand_a;
    eeg_pkg::t_data operand_b;
    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface eeg_out_if;
    logic           valid;
    logic           ready;
    eeg_pkg::t_data divisor;
    eeg_pkg::t_coef coef_a;
    eeg_pkg::t_coef coef_b;
    modport source (output valid, output divisor, output coef_a, output coef_b,
                    input ready);
    modport sink   (input valid, input divisor, input coef_a, input coef_b,
                    output ready);
endinterface

FILE: hw/rtl/extended_euclid_gcd_unit.sv
// ----------------------------------------------------------------------------
// extended_euclid_gcd_unit: greatest common divisor with Bezout coefficients
// Returns gcd(a, b) and coefficients with a*coef_a + b*coef_b = gcd.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// i_in      sink       operand_a, operand_b (32 bits each, unsigned)
// o_out     source     divisor (32 bits), coef_a, coef_b (33 bits, signed)
//
// Each Euclid iteration runs a check state, a restoring division of one
// quotient bit per cycle plus its finish, and the UPDX and UPDY states in
// which the single shared multiplier updates each coefficient row. The
// result is offered once a division leaves a zero remainder (straight after
// the check state when the smaller operand is zero), and the next operand
// transaction can be accepted in the cycle after the result leaves.
// Reset (synchronous, active low) returns the sequencer to idle; one
// transaction is worked at a time, and the result holds while o_out stalls.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_unit (
    input logic     i_clk,
    input logic     i_rst_n,
    eeg_in_if.sink  i_in,
    eeg_out_if.source o_out
);
    eeg_pkg::t_cmd    cmd;
    eeg_pkg::t_status status;

    // The sequencer issues the datapath commands and watches division status.
    eeg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath keeps the rows; its outputs are stable while the result waits.
    eeg_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_operand_a (i_in.operand_a),
        .i_operand_b (i_in.operand_b),
        .o_status    (status),
        .o_divisor   (o_out.divisor),
        .o_coef_a    (o_out.coef_a),
        .o_coef_b    (o_out.coef_b)
    );

    // Input and output are never both offered by the sequencer.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("ready and valid together");

    // A result held back by the sink keeps its divisor and coef_a.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.divisor) &&
        $stable(o_out.coef_a)) else $error("result changed while stalled");

    // Row updates only follow a finished division.
    a_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd_x |-> $past(status.div_done)) else $error("update without division");
endmodule

FILE: hw/rtl/eeg_datapath.sv
// ----------------------------------------------------------------------------
// eeg_datapath: remainder and coefficient registers of the GCD unit
// Holds the remainder rows, a restoring divider and one shared multiplier.
// ----------------------------------------------------------------------------
module eeg_datapath (
    input  logic             i_clk,
    input  eeg_pkg::t_cmd    i_cmd,
    input  eeg_pkg::t_data   i_operand_a,
    input  eeg_pkg::t_data   i_operand_b,
    output eeg_pkg::t_status o_status,
    output eeg_pkg::t_data   o_divisor,
    output eeg_pkg::t_coef   o_coef_a,
    output eeg_pkg::t_coef   o_coef_b
);
    localparam int W  = eeg_pkg::WIDTH;
    localparam int CW = eeg_pkg::CWIDTH;
    localparam int NW = eeg_pkg::CNT_W;

    logic [W-1:0]  r_rp, r_rc, r_q, r_rem, r_num;
    logic [CW-1:0] r_xp, r_xc, r_yp, r_yc;
    logic          r_swapped, r_small_zero;
    logic [NW-1:0] r_cnt;

    logic          swapped;
    logic [W:0]    trial;
    logic [W-1:0]  rem_sh;
    logic [CW-1:0] mul_in, mul_lo;
    logic [W+CW-1:0] prod;

    assign swapped = i_operand_a < i_operand_b;
    assign rem_sh  = {r_rem[W-2:0], r_num[W-1]};
    assign trial   = {r_rem[W-1], rem_sh} - {1'b0, r_rc};

    // One multiplier shared by the two row updates; modulo 2^CW suffices.
    assign mul_in = i_cmd.upd_x ? r_xc : r_yc;
    assign prod   = {{(CW-W){1'b0}}, r_q} * mul_in;
    assign mul_lo = prod[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_swapped    <= swapped;
            r_rp         <= swapped ? i_operand_b : i_operand_a;
            r_rc         <= swapped ? i_operand_a : i_operand_b;
            r_small_zero <= (swapped ? i_operand_a : i_operand_b) == '0;
            r_xp <= CW'(1); r_xc <= '0;
            r_yp <= '0;     r_yc <= CW'(1);
        end
        if (i_cmd.div_start) begin
            r_num <= r_rp;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[W-2:0], 1'b0};
            end
            r_num <= {r_num[W-2:0], 1'b0};
            r_cnt <= r_cnt + NW'(1);
        end
        if (i_cmd.upd_x) begin
            r_xp <= r_xc;
            r_xc <= r_xp - mul_lo;
        end
        if (i_cmd.upd_y) begin
            r_yp <= r_yc;
            r_yc <= r_yp - mul_lo;
            r_rp <= r_rc;
            r_rc <= r_rem;
        end
    end

    assign o_status.small_zero = r_small_zero;
    assign o_status.div_done   = r_cnt == NW'(W);
    assign o_status.rem_zero   = r_rem == '0;

    // With a zero small operand, rp holds the big one and the rows are initial.
    assign o_divisor = r_small_zero ? r_rp : r_rc;
    assign o_coef_a  = r_small_zero ? (r_swapped ? r_yp : r_xp)
                                    : (r_swapped ? r_yc : r_xc);
    assign o_coef_b  = r_small_zero ? (r_swapped ? r_xp : r_yp)
                                    : (r_swapped ? r_xc : r_yc);
endmodule

FILE: hw/rtl/eeg_ctrl.sv
// ----------------------------------------------------------------------------
// eeg_ctrl: sequencer of the GCD unit
// Steps through load, division, row updates and result delivery.
// ----------------------------------------------------------------------------
module eeg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  eeg_pkg::t_status i_status,
    output eeg_pkg::t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_UPDX  = 3'd3;
    localparam logic [2:0] S_UPDY  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.small_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_status.rem_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_UPDX;
                end
            end
            S_UPDX: begin
                o_cmd.upd_x = 1'b1;
                n_state     = S_UPDY;
            end
            S_UPDY: begin
                o_cmd.upd_y = 1'b1;
                n_state     = S_CHECK;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
